>>> rtl/dsq_pkg.sv
`default_nettype none

package dsq_pkg;

  // Field and register widths
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned COUNT_W       = 4;
  localparam int unsigned ROW_W         = 3;
  localparam int unsigned COL_W         = 3;
  localparam int unsigned POS_ROW_W     = 6;
  localparam int unsigned CELLS_PER_REG = CFG_W / BYTE_W;
  localparam int unsigned GRID_LIMIT    = 8;
  localparam int unsigned MAX_CELLS_DEF = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(5);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_B  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_C  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_D  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COL_CNT  = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] first_symbol;
    logic [BYTE_W-1:0] second_symbol;
  } dsq_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_cipher;
    logic [BYTE_W-1:0] second_cipher;
    logic              symbol_missing;
  } dsq_out_t;

  // Effective square geometry, both counts in 1..8
  typedef struct packed {
    logic [COUNT_W-1:0] rows;
    logic [COUNT_W-1:0] cols;
  } geom_t;

  // Locate lane: a request travelling the chain, collecting match positions
  typedef struct packed {
    logic                 valid;
    logic [BYTE_W-1:0]    first_symbol;
    logic [BYTE_W-1:0]    second_symbol;
    logic [POS_ROW_W-1:0] pos_r;
    logic [COL_W-1:0]     pos_c;
    logic [ROW_W-1:0]     a_r;
    logic [COL_W-1:0]     a_c;
    logic [ROW_W-1:0]     b_r;
    logic [COL_W-1:0]     b_c;
    logic                 a_found;
    logic                 b_found;
  } loc_lane_t;

  // Pick lane: a request travelling the chain, collecting target bytes
  typedef struct packed {
    logic                 valid;
    logic [POS_ROW_W-1:0] pos_r;
    logic [COL_W-1:0]     pos_c;
    logic [ROW_W-1:0]     t1_r;
    logic [COL_W-1:0]     t1_c;
    logic [ROW_W-1:0]     t2_r;
    logic [COL_W-1:0]     t2_c;
    dsq_out_t             res;
  } pick_lane_t;

endpackage

`default_nettype wire

>>> rtl/dsq_cell.sv
`default_nettype none

module dsq_cell import dsq_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire geom_t             geom_i,
  input  wire logic              wr_en_i,
  input  wire logic [BYTE_W-1:0] wr_byte_i,
  input  wire loc_lane_t         loc_i,
  output loc_lane_t              loc_o,
  input  wire pick_lane_t        pick_i,
  output pick_lane_t             pick_o
);

  logic [BYTE_W-1:0] byte_q;
  loc_lane_t         loc_q, loc_d;
  pick_lane_t        pick_q, pick_d;

  logic                 loc_wrap, pick_wrap, in_use;
  logic [POS_ROW_W-1:0] loc_r_next, pick_r_next;
  logic [COL_W-1:0]     loc_c_next, pick_c_next;

  // Advance the row-major position by one cell
  always_comb begin
    loc_wrap    = ({1'b0, loc_i.pos_c} + COUNT_W'(1)) == geom_i.cols;
    loc_c_next  = loc_wrap ? '0 : loc_i.pos_c + COL_W'(1);
    loc_r_next  = loc_wrap ? loc_i.pos_r + POS_ROW_W'(1) : loc_i.pos_r;
    pick_wrap   = ({1'b0, pick_i.pos_c} + COUNT_W'(1)) == geom_i.cols;
    pick_c_next = pick_wrap ? '0 : pick_i.pos_c + COL_W'(1);
    pick_r_next = pick_wrap ? pick_i.pos_r + POS_ROW_W'(1) : pick_i.pos_r;
  end

  // Locate: a later match overrides an earlier one
  always_comb begin
    in_use      = loc_i.pos_r < {2'b0, geom_i.rows};
    loc_d       = loc_i;
    loc_d.pos_r = loc_r_next;
    loc_d.pos_c = loc_c_next;
    if (in_use && (byte_q == loc_i.first_symbol)) begin
      loc_d.a_r     = loc_i.pos_r[ROW_W-1:0];
      loc_d.a_c     = loc_i.pos_c;
      loc_d.a_found = 1'b1;
    end
    if (in_use && (byte_q == loc_i.second_symbol)) begin
      loc_d.b_r     = loc_i.pos_r[ROW_W-1:0];
      loc_d.b_c     = loc_i.pos_c;
      loc_d.b_found = 1'b1;
    end
  end

  // Pick: drop this cell's byte into whichever target sits here
  always_comb begin
    pick_d       = pick_i;
    pick_d.pos_r = pick_r_next;
    pick_d.pos_c = pick_c_next;
    if ((pick_i.pos_r == {3'b0, pick_i.t1_r}) && (pick_i.pos_c == pick_i.t1_c)) begin
      pick_d.res.first_cipher = byte_q;
    end
    if ((pick_i.pos_r == {3'b0, pick_i.t2_r}) && (pick_i.pos_c == pick_i.t2_c)) begin
      pick_d.res.second_cipher = byte_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (wr_en_i) begin
      byte_q <= wr_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q  <= '0;
      pick_q <= '0;
    end else if (en_i) begin
      loc_q  <= loc_d;
      pick_q <= pick_d;
    end
  end

  assign loc_o  = loc_q;
  assign pick_o = pick_q;

endmodule

`default_nettype wire

>>> rtl/dsq_resolve.sv
`default_nettype none

module dsq_resolve import dsq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire geom_t     geom_i,
  input  wire loc_lane_t loc_i,
  output pick_lane_t     pick_o
);

  pick_lane_t       pick_q, pick_d;
  logic [COL_W-1:0] ac_next, bc_next;
  logic [ROW_W-1:0] ar_next, br_next;

  always_comb begin
    ac_next = (({1'b0, loc_i.a_c} + COUNT_W'(1)) == geom_i.cols) ? '0 : loc_i.a_c + COL_W'(1);
    bc_next = (({1'b0, loc_i.b_c} + COUNT_W'(1)) == geom_i.cols) ? '0 : loc_i.b_c + COL_W'(1);
    ar_next = (({1'b0, loc_i.a_r} + COUNT_W'(1)) == geom_i.rows) ? '0 : loc_i.a_r + ROW_W'(1);
    br_next = (({1'b0, loc_i.b_r} + COUNT_W'(1)) == geom_i.rows) ? '0 : loc_i.b_r + ROW_W'(1);

    pick_d                    = '0;
    pick_d.valid              = loc_i.valid;
    pick_d.res.symbol_missing = !(loc_i.a_found && loc_i.b_found);
    if (loc_i.a_r == loc_i.b_r) begin
      // Same row, identical pair included: step right
      pick_d.t1_r = loc_i.a_r;
      pick_d.t1_c = ac_next;
      pick_d.t2_r = loc_i.b_r;
      pick_d.t2_c = bc_next;
    end else if (loc_i.a_c == loc_i.b_c) begin
      // Same column: step down
      pick_d.t1_r = ar_next;
      pick_d.t1_c = loc_i.a_c;
      pick_d.t2_r = br_next;
      pick_d.t2_c = loc_i.b_c;
    end else begin
      // Rectangle: swap columns
      pick_d.t1_r = loc_i.a_r;
      pick_d.t1_c = loc_i.b_c;
      pick_d.t2_r = loc_i.b_r;
      pick_d.t2_c = loc_i.a_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pick_q <= '0;
    end else if (en_i) begin
      pick_q <= pick_d;
    end
  end

  assign pick_o = pick_q;

endmodule

`default_nettype wire

>>> rtl/digraph_square_substitution_top.sv
// Throughput: one request per cycle while the skid stage is empty; both lanes of the
// cell chain advance together, and the whole chain stops while the skid stage is full.
// A request walks every cell twice, once to locate its symbols and once to pick the
// cipher bytes.
// Reset: asynchronous, active low; clears the pipeline, the key square to zero and both
// counts to 5. No clearing pass; the block accepts requests straight after reset.
`default_nettype none

module digraph_square_substitution_top import dsq_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Request channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire dsq_in_t              in_data_i,
  // Result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output dsq_out_t                  out_data_o,
  // Configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  // Geometry registers; the key bytes live inside the cells
  logic [COUNT_W-1:0] row_count_q, col_count_q;
  logic [COUNT_W-1:0] rows_cl, cols_cl;
  geom_t              geom;

  // Pipeline control
  logic      en;
  loc_lane_t in_q, in_d;

  // Output register and skid stage
  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  dsq_out_t out_q, out_d;
  dsq_out_t skid_q, skid_d;
  logic     take;

  loc_lane_t  loc_chain  [MAX_CELLS+1];
  pick_lane_t pick_chain [MAX_CELLS+1];

  // ---------------------------------------------------------------------------
  // Configuration: counts here, cell bytes decoded per cell below
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= COUNT_RESET;
      col_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ROW_CNT) begin
        row_count_q <= cfg_wdata_i[COUNT_W-1:0];
      end
      if (cfg_idx_i == REG_COL_CNT) begin
        col_count_q <= cfg_wdata_i[COUNT_W-1:0];
      end
    end
  end

  // Clamp both counts to 1..8, limit columns to the cell count, then drop rows
  // until the square fits in the chain.
  always_comb begin
    rows_cl = (row_count_q == '0) ? COUNT_W'(1) :
              (row_count_q > COUNT_W'(GRID_LIMIT)) ? COUNT_W'(GRID_LIMIT) : row_count_q;
    cols_cl = (col_count_q == '0) ? COUNT_W'(1) :
              (col_count_q > COUNT_W'(GRID_LIMIT)) ? COUNT_W'(GRID_LIMIT) : col_count_q;
    geom.cols = ({2'b0, cols_cl} > 6'(MAX_CELLS)) ? COUNT_W'(MAX_CELLS) : cols_cl;
    geom.rows = COUNT_W'(1);
    for (int r = 1; r <= GRID_LIMIT; r++) begin
      if ((COUNT_W'(r) <= rows_cl) &&
          (({4'b0, COUNT_W'(r)} * {4'b0, geom.cols}) <= 8'(MAX_CELLS))) begin
        geom.rows = COUNT_W'(r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole chain advances while the skid stage is empty, so
  // the request side sees a registered stall.
  // ---------------------------------------------------------------------------
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_comb begin
    in_d               = '0;
    in_d.valid         = in_valid_i;
    in_d.first_symbol  = in_data_i.first_symbol;
    in_d.second_symbol = in_data_i.second_symbol;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (en) begin
      in_q <= in_d;
    end
  end

  assign loc_chain[0] = in_q;

  // ---------------------------------------------------------------------------
  // Cell chain: cell k holds key byte k and serves both lanes
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_CELLS; k++) begin : g_cell
    localparam int unsigned BANK = k / CELLS_PER_REG;
    localparam int unsigned LANE = k % CELLS_PER_REG;

    logic wr_en;
    assign wr_en = cfg_we_i && (cfg_idx_i == (REG_CELLS_A + CFG_IDX_W'(BANK)));

    dsq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .geom_i    (geom),
      .wr_en_i   (wr_en),
      .wr_byte_i (cfg_wdata_i[LANE*BYTE_W +: BYTE_W]),
      .loc_i     (loc_chain[k]),
      .loc_o     (loc_chain[k+1]),
      .pick_i    (pick_chain[k]),
      .pick_o    (pick_chain[k+1])
    );
  end

  // Turn match positions into target positions, feeding the pick lane
  dsq_resolve u_resolve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .geom_i (geom),
    .loc_i  (loc_chain[MAX_CELLS]),
    .pick_o (pick_chain[0])
  );

  // ---------------------------------------------------------------------------
  // Output register with skid stage: park a result in the skid register when
  // the output is held, and refill the output from it once taken.
  // ---------------------------------------------------------------------------
  assign take = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (take) begin
      out_valid_d  = skid_valid_q;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
    if (en && pick_chain[MAX_CELLS].valid) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_d       = pick_chain[MAX_CELLS].res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = pick_chain[MAX_CELLS].res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid stage filled without a held output");

  a_geom_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (geom.rows != '0) && (geom.cols != '0) &&
    (({4'b0, geom.rows} * {4'b0, geom.cols}) <= 8'(MAX_CELLS)))
    else $error("effective square exceeds the cell chain");

endmodule

`default_nettype wire

>>> tb/digraph_square_substitution_top_test.sv
`timescale 1ns / 100ps

module digraph_square_substitution_top_test;
  import dsq_pkg::*;

  // Request-to-result latency given for a 32-cell build; used for settling waits
  localparam int unsigned PIPE_LATENCY = 2 * 32 + 2;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  dsq_in_t              in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  dsq_out_t             out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = REG_CELLS_A;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  // Mirror of the configuration as last written to the block
  logic [BYTE_W-1:0]  key_square [32];
  logic [COUNT_W-1:0] square_rows_reg;
  logic [COUNT_W-1:0] square_cols_reg;

  // Cipher pairs predicted for accepted requests, oldest first
  dsq_out_t pending_ciphers[$];
  dsq_out_t oldest_cipher;
  int       mismatch_count = 0;

  // Idling probabilities in percent, changed per traffic regime
  int send_gap_pct = 26;
  int stall_pct    = 68;

  digraph_square_substitution_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result-side back-pressure: redraw the stall at every falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Square geometry as the block sees it: clamp both counts into 1..8, then cut
  // the rows back so that the square never exceeds 32 cells.
  // ---------------------------------------------------------------------------
  function automatic int used_cols();
    if (square_cols_reg == 0) return 1;
    if (square_cols_reg > GRID_LIMIT) return GRID_LIMIT;
    return int'(square_cols_reg);
  endfunction

  function automatic int used_rows();
    int rows;
    int cols;
    cols = used_cols();
    rows = (square_rows_reg == 0) ? 1 :
           (square_rows_reg > GRID_LIMIT) ? GRID_LIMIT : int'(square_rows_reg);
    if (rows * cols > 32) rows = 32 / cols;
    return rows;
  endfunction

  function automatic logic [BYTE_W-1:0] square_cell(int row, int col, int cols);
    return key_square[(row * cols + col) & 31];
  endfunction

  // Scan row-major and keep the last hit, so a repeated byte resolves to its
  // highest cell; a miss leaves the symbol parked at the top-left cell.
  function automatic bit locate_symbol(input logic [BYTE_W-1:0] sym, input int rows,
                                       input int cols, output int row, output int col);
    bit hit;
    hit = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (square_cell(r, c, cols) == sym) begin
          row = r;
          col = c;
          hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic dsq_out_t encipher_pair(dsq_in_t req);
    int       rows;
    int       cols;
    int       ar, ac, br, bc;
    bit       a_hit, b_hit;
    dsq_out_t res;
    cols  = used_cols();
    rows  = used_rows();
    a_hit = locate_symbol(req.first_symbol, rows, cols, ar, ac);
    b_hit = locate_symbol(req.second_symbol, rows, cols, br, bc);
    if (ar == br) begin
      // Shared row, identical pair included: step right with wrap
      res.first_cipher  = square_cell(ar, (ac + 1 == cols) ? 0 : ac + 1, cols);
      res.second_cipher = square_cell(br, (bc + 1 == cols) ? 0 : bc + 1, cols);
    end else if (ac == bc) begin
      // Shared column: step down with wrap
      res.first_cipher  = square_cell((ar + 1 == rows) ? 0 : ar + 1, ac, cols);
      res.second_cipher = square_cell((br + 1 == rows) ? 0 : br + 1, bc, cols);
    end else begin
      // Rectangle: swap the columns
      res.first_cipher  = square_cell(ar, bc, cols);
      res.second_cipher = square_cell(br, ac, cols);
    end
    res.symbol_missing = !(a_hit && b_hit);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result must match the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ciphers.size() == 0) begin
        $error("unexpected result %h with no request outstanding", out_data_o);
        mismatch_count++;
      end else begin
        oldest_cipher = pending_ciphers.pop_front();
        if (out_data_o.first_cipher !== oldest_cipher.first_cipher) begin
          $error("first_cipher: expected %02h, got %02h",
                 oldest_cipher.first_cipher, out_data_o.first_cipher);
          mismatch_count++;
        end
        if (out_data_o.second_cipher !== oldest_cipher.second_cipher) begin
          $error("second_cipher: expected %02h, got %02h",
                 oldest_cipher.second_cipher, out_data_o.second_cipher);
          mismatch_count++;
        end
        if (out_data_o.symbol_missing !== oldest_cipher.symbol_missing) begin
          $error("symbol_missing: expected %0b, got %0b",
                 oldest_cipher.symbol_missing, out_data_o.symbol_missing);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver. Inputs move on the falling edge; acceptance is judged on the
  // rising edge. Valid is left high on return so back-to-back requests stream
  // without a bubble; hold_until_drained drops it.
  // ---------------------------------------------------------------------------
  task automatic send_pair(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
    dsq_in_t req;
    req.first_symbol  = first;
    req.second_symbol = second;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_ciphers.push_back(encipher_pair(req));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_ciphers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all six registers from the mirror, back to back, once the block is idle
  task automatic load_key();
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     word;
    hold_until_drained();
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: idx = REG_CELLS_A;
        1: idx = REG_CELLS_B;
        2: idx = REG_CELLS_C;
        3: idx = REG_CELLS_D;
        4: idx = REG_ROW_CNT;
        default: idx = REG_COL_CNT;
      endcase
      if (i < 4) begin
        for (int k = 0; k < 8; k++) word[8*k +: 8] = key_square[8*i + k];
      end else begin
        word = (i == 4) ? CFG_W'(square_rows_reg) : CFG_W'(square_cols_reg);
      end
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= word;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Fill the whole square: distinct bytes, or a narrow alphabet full of repeats
  task automatic fill_square(input bit with_repeats);
    bit          taken [256];
    logic [7:0]  base;
    logic [7:0]  pick;
    foreach (taken[i]) taken[i] = 1'b0;
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < 32; i++) begin
      if (with_repeats) begin
        key_square[i] = base ^ 8'($urandom_range(0, 5));
      end else begin
        do pick = 8'($urandom_range(0, 255)); while (taken[pick]);
        taken[pick]   = 1'b1;
        key_square[i] = pick;
      end
    end
  endtask

  // Mostly symbols from cells in use, the rest any byte; now and then a double
  task automatic send_random_pair(input int in_square_pct);
    int         span;
    logic [7:0] first;
    logic [7:0] second;
    span   = used_rows() * used_cols();
    first  = ($urandom_range(0, 99) < in_square_pct) ?
             key_square[$urandom_range(0, span - 1)] : 8'($urandom_range(0, 255));
    second = ($urandom_range(0, 99) < in_square_pct) ?
             key_square[$urandom_range(0, span - 1)] : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) second = first;
    send_pair(first, second);
  endtask

  function automatic logic [COUNT_W-1:0] random_count();
    if ($urandom_range(0, 3) == 0) return COUNT_W'($urandom_range(0, 15));
    return COUNT_W'($urandom_range(1, 8));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset: square all zeros, 5x5. Zero resolves to the last cell in use;
  // anything else is missing and parks at the top-left.
  task automatic test_reset_square();
    send_pair(8'h00, 8'h00);
    send_pair(8'h12, 8'h00);
    send_pair(8'h34, 8'hFF);
  endtask

  // 5x5 square with 00 in the first cell, FF in the last, letters between and
  // unused cells beyond that must never match.
  task automatic test_cipher_rules();
    key_square[0]  = 8'h00;
    for (int i = 1; i < 24; i++) key_square[i] = 8'h41 + 8'(i);
    key_square[24] = 8'hFF;
    for (int i = 25; i < 32; i++) key_square[i] = 8'h80 + 8'(i);
    square_rows_reg = 4'd5;
    square_cols_reg = 4'd5;
    load_key();
    send_pair(key_square[6],  key_square[18]);  // rectangle
    send_pair(key_square[6],  key_square[8]);   // shared row
    send_pair(key_square[9],  key_square[5]);   // shared row, wrap to column 0
    send_pair(key_square[2],  key_square[12]);  // shared column
    send_pair(key_square[22], key_square[7]);   // shared column, wrap to row 0
    send_pair(key_square[13], key_square[13]);  // identical pair
    send_pair(8'h99, key_square[12]);           // first missing (lives in unused cell)
    send_pair(key_square[3], 8'h7F);            // second missing
    send_pair(8'h99, 8'h7F);                    // both missing
    send_pair(8'h00, 8'hFF);                    // field extremes, opposite corners
    send_pair(8'hFF, 8'hFF);                    // identical at the last cell
    // Repeat a byte: the higher cell must win
    key_square[7] = key_square[3];
    load_key();
    send_pair(key_square[3], key_square[11]);
    send_pair(key_square[11], key_square[7]);
  endtask

  // Count extremes, including zero, values above eight and oversized squares
  task automatic test_geometry_extremes();
    for (int i = 0; i < 10; i++) begin
      case (i)
        0: begin square_rows_reg = 4'd1;  square_cols_reg = 4'd1;  end
        1: begin square_rows_reg = 4'd1;  square_cols_reg = 4'd8;  end
        2: begin square_rows_reg = 4'd8;  square_cols_reg = 4'd1;  end
        3: begin square_rows_reg = 4'd8;  square_cols_reg = 4'd4;  end
        4: begin square_rows_reg = 4'd4;  square_cols_reg = 4'd8;  end
        5: begin square_rows_reg = 4'd8;  square_cols_reg = 4'd8;  end
        6: begin square_rows_reg = 4'd0;  square_cols_reg = 4'd0;  end
        7: begin square_rows_reg = 4'd15; square_cols_reg = 4'd15; end
        8: begin square_rows_reg = 4'd6;  square_cols_reg = 4'd6;  end
        default: begin square_rows_reg = 4'd7; square_cols_reg = 4'd5; end
      endcase
      fill_square(1'b0);
      load_key();
      send_random_pair(100);
    end
  endtask

  // Bulk traffic in three idling regimes, reloading the key square per phase
  task automatic test_random_traffic();
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin send_gap_pct = 26; stall_pct = 68; end
        1: begin send_gap_pct = 68; stall_pct = 26; end
        default: begin send_gap_pct = 0; stall_pct = 0; end
      endcase
      for (int phase = 0; phase < 8; phase++) begin
        fill_square($urandom_range(0, 3) == 0);
        square_rows_reg = random_count();
        square_cols_reg = random_count();
        load_key();
        for (int n = 0; n < 71; n++) begin
          send_random_pair(80);
          // Pause the sender now and then until the pipe has emptied
          if ($urandom_range(0, 199) == 0) hold_until_drained();
        end
      end
    end
  endtask

  initial begin
    foreach (key_square[i]) key_square[i] = '0;
    square_rows_reg = COUNT_RESET;
    square_cols_reg = COUNT_RESET;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_square();
    test_cipher_rules();
    test_geometry_extremes();
    test_random_traffic();

    hold_until_drained();
    repeat (PIPE_LATENCY + 10) @(negedge clk_i);
    if (pending_ciphers.size() != 0) begin
      $error("%0d predicted results never arrived", pending_ciphers.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/dsq_pkg.sv
rtl/dsq_cell.sv
rtl/dsq_resolve.sv
rtl/digraph_square_substitution_top.sv
tb/digraph_square_substitution_top_test.sv
